@@ hdl/fid_pkg.sv @@
// Package for the first-occurrence id assigner: field widths, defaults,
// controller state codes and the result word layout. No dependencies.
`timescale 1ns / 1ps

package fid_pkg;

   localparam int DEF_MAX_KEYS = 128;
   localparam int DEF_KEY_BITS = 16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int ID_OUT_W   = 7;
   localparam int CNT_OUT_W  = 8;
   localparam int LIMIT_W    = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } ctrl_state_type;

   // result word, lowest field last in the declaration
   typedef struct packed {
      logic                 overflow;
      logic                 over_limit;
      logic [CNT_OUT_W-1:0] distinct_count;
      logic                 is_new;
      logic [ID_OUT_W-1:0]  assigned_id;
   } rsp_word_type;

   localparam int RSP_WORD_W = $bits(rsp_word_type);

endpackage

@@ hdl/fid_cell.sv @@
// One key cell of the search chain: holds one distinct key and compares the
// probe passing through it. Depends on fid_pkg.
`timescale 1ns / 1ps

module fid_cell import fid_pkg::*; #(
   parameter int MAX_KEYS = DEF_MAX_KEYS,
   parameter int KEY_BITS = DEF_KEY_BITS,
   parameter int INDEX    = 0,
   localparam int ID_W    = $clog2(MAX_KEYS),
   localparam int CNT_W   = $clog2(MAX_KEYS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_found,
   input  logic [ID_W-1:0]     in_id,
   input  logic [KEY_BITS-1:0] in_key,
   output logic                out_valid,
   output logic                out_found,
   output logic [ID_W-1:0]     out_id,
   output logic [KEY_BITS-1:0] out_key,
   input  logic [CNT_W-1:0]    total,
   input  logic                wr_en,
   input  logic [ID_W-1:0]     wr_idx,
   input  logic [KEY_BITS-1:0] wr_key
);

   logic [KEY_BITS-1:0] stored_ff;
   logic                vld_ff;
   logic                found_ff, found_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [KEY_BITS-1:0] key_ff;
   logic                hit;

   // only cells below the distinct count hold a live key
   assign hit = in_valid && !in_found && (CNT_W'(INDEX) < total) && (stored_ff == in_key);

   always_comb begin
      found_in = in_found | hit;
      id_in    = hit ? ID_W'(INDEX) : in_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      id_ff    <= id_in;
      key_ff   <= in_key;
      if (wr_en && (wr_idx == ID_W'(INDEX))) begin
         stored_ff <= wr_key;
      end
   end

   assign out_valid = vld_ff;
   assign out_found = found_ff;
   assign out_id    = id_ff;
   assign out_key   = key_ff;

endmodule

@@ hdl/fid_ctrl.sv @@
// Controller: stream handshakes, limit register, list counters, result
// register and the append write into the cell chain. Depends on fid_pkg.
`timescale 1ns / 1ps

module fid_ctrl import fid_pkg::*; #(
   parameter int MAX_KEYS = DEF_MAX_KEYS,
   parameter int KEY_BITS = DEF_KEY_BITS,
   localparam int ID_W    = $clog2(MAX_KEYS),
   localparam int CNT_W   = $clog2(MAX_KEYS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_W-1:0]    csr_data,
   output logic                  inj_valid,
   output logic [KEY_BITS-1:0]   inj_key,
   input  logic                  done_valid,
   input  logic                  done_found,
   input  logic [ID_W-1:0]       done_id,
   input  logic [KEY_BITS-1:0]   done_key,
   output logic                  wr_en,
   output logic [ID_W-1:0]       wr_idx,
   output logic [KEY_BITS-1:0]   wr_key,
   output logic [CNT_W-1:0]      total
);

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   ctrl_state_type     state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic               last_ff, last_in;
   rsp_word_type       pend_ff, pend_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   new_total;
   logic [ID_W-1:0]    new_id;
   logic               fresh;
   logic               req_accept;

   // hold both channels off while reset is high
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign inj_key    = KEY_BITS'(req_tdata);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      seen_in      = seen_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      inj_valid    = 1'b0;
      wr_en        = 1'b0;
      new_total    = total_ff;
      new_id       = '0;
      fresh        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_tlast;
               if (seen_ff >= CNT_W'(MAX_KEYS)) begin
                  // list is full: drop the word, no search
                  pend_in.assigned_id    = '0;
                  pend_in.is_new         = 1'b0;
                  pend_in.distinct_count = CNT_OUT_W'(total_ff);
                  pend_in.over_limit     = req_tlast &&
                                           (CMP_W'(total_ff) > CMP_W'(limit_ff));
                  pend_in.overflow       = 1'b1;
                  if (req_tlast) begin
                     total_in = '0;
                     seen_in  = '0;
                  end
                  state_in = ST_DONE;
               end else begin
                  seen_in   = seen_ff + 1'b1;
                  inj_valid = 1'b1;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (done_valid) begin
               if (done_found) begin
                  new_id = done_id;
               end else if (total_ff < CNT_W'(MAX_KEYS)) begin
                  // append the key behind the last distinct one
                  new_id    = total_ff[ID_W-1:0];
                  wr_en     = 1'b1;
                  new_total = total_ff + 1'b1;
                  fresh     = 1'b1;
               end
               pend_in.assigned_id    = ID_OUT_W'(new_id);
               pend_in.is_new         = fresh;
               pend_in.distinct_count = CNT_OUT_W'(new_total);
               pend_in.over_limit     = last_ff && (CMP_W'(new_total) > CMP_W'(limit_ff));
               pend_in.overflow       = 1'b0;
               if (last_ff) begin
                  total_in = '0;
                  seen_in  = '0;
               end else begin
                  total_in = new_total;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_idx = total_ff[ID_W-1:0];
   assign wr_key = done_key;
   assign total  = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         total_ff     <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_WORD_W){1'b0}}, rsp_ff};

   a_total_le_seen: assert property (@(posedge clock) disable iff (reset)
      total_ff <= seen_ff)
      else $error("distinct count above entries taken");

   a_seen_max: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_KEYS))
      else $error("entry count beyond list capacity");

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      done_valid |-> (state_ff == ST_SEARCH))
      else $error("chain result outside a search");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_write_is_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (total_ff == $past(total_ff) + 1'b1) || $past(last_ff))
      else $error("append write without count advance");

endmodule

@@ hdl/first_occurrence_id_assigner_top.sv @@
// Top level of the first-occurrence id assigner: a chain of MAX_KEYS key
// cells and its controller. Depends on fid_pkg, fid_cell and fid_ctrl.
// The probe walks the cell chain one cell per cycle; its result then passes
// the pending and response registers to rsp_tvalid. A dropped word skips the chain.
// A new req is taken only once the last word's response is registered, so words
// do not overlap in the chain; a stalled rsp holds off the next req.
// Reset: synchronous; clears counters, limit to 64; cell keys not cleared.
`timescale 1ns / 1ps

module first_occurrence_id_assigner_top import fid_pkg::*; #(
   parameter int MAX_KEYS = DEF_MAX_KEYS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] key_value
   input  logic                  req_tlast,  // last_entry
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] assigned_id, [7] is_new, [15:8] distinct_count, [16] over_limit,
   // [17] overflow, [23:18] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_W-1:0]    csr_data    // distinct_limit
);

   localparam int ID_W  = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   logic [MAX_KEYS:0]   p_valid;
   logic [MAX_KEYS:0]   p_found;
   logic [ID_W-1:0]     p_id  [0:MAX_KEYS];
   logic [KEY_BITS-1:0] p_key [0:MAX_KEYS];

   logic                wr_en;
   logic [ID_W-1:0]     wr_idx;
   logic [KEY_BITS-1:0] wr_key;
   logic [CNT_W-1:0]    total;

   assign p_found[0] = 1'b0;
   assign p_id[0]    = '0;

   fid_ctrl #(
      .MAX_KEYS (MAX_KEYS),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .inj_valid  (p_valid[0]),
      .inj_key    (p_key[0]),
      .done_valid (p_valid[MAX_KEYS]),
      .done_found (p_found[MAX_KEYS]),
      .done_id    (p_id[MAX_KEYS]),
      .done_key   (p_key[MAX_KEYS]),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_key     (wr_key),
      .total      (total)
   );

   for (genvar gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
      fid_cell #(
         .MAX_KEYS (MAX_KEYS),
         .KEY_BITS (KEY_BITS),
         .INDEX    (gi)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (p_valid[gi]),
         .in_found  (p_found[gi]),
         .in_id     (p_id[gi]),
         .in_key    (p_key[gi]),
         .out_valid (p_valid[gi+1]),
         .out_found (p_found[gi+1]),
         .out_id    (p_id[gi+1]),
         .out_key   (p_key[gi+1]),
         .total     (total),
         .wr_en     (wr_en),
         .wr_idx    (wr_idx),
         .wr_key    (wr_key)
      );
   end

endmodule

@@ tb/first_occurrence_id_assigner_top_tb.sv @@
// Self-checking bench for first_occurrence_id_assigner_top: a directed table,
// a saturating list, then random key lists under changing limits and idling.
// Depends on fid_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module first_occurrence_id_assigner_top_tb;
   import fid_pkg::*;

   localparam int MAX_KEYS   = DEF_MAX_KEYS;
   localparam int ITEM_GOAL  = 1950;
   localparam int NUM_PHASES = 8;
   localparam int SETTLE_CYC = MAX_KEYS + 12;

   typedef struct packed {
      logic [REQ_DATA_W-1:0] key;
      logic                  last;
      logic                  typed;   // row carries its own expected word
      rsp_word_type          word;
   } dir_row_type;

   // word pattern order: overflow, over_limit, distinct_count, is_new, assigned_id
   localparam dir_row_type DIR_ROWS [16] = '{
      '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd1, 1'b1, 7'd0}},
      '{16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd2, 1'b1, 7'd1}},
      '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd2, 1'b0, 7'd0}},
      '{16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd2, 1'b0, 7'd1}},
      '{16'h1452, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd1, 1'b1, 7'd0}},
      '{16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd1, 1'b1, 7'd0}},
      '{16'hAAAA, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b0, 1'b0, '0},
      '{16'hAAAA, 1'b0, 1'b0, '0},
      '{16'h1452, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b0, 1'b0, '0},
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'h8000, 1'b0, 1'b0, '0},
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'h7FFF, 1'b0, 1'b0, '0},
      '{16'h1452, 1'b1, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] key_value
   logic                  req_tlast = 1'b0; // last_entry
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [6:0] assigned_id, [7] is_new, [15:8] distinct_count, [16] over_limit,
   // [17] overflow, [23:18] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data = '0;    // distinct_limit

   // shadow of the block state
   logic [REQ_DATA_W-1:0] seen_keys [MAX_KEYS];
   int unsigned           key_count = 0;
   int unsigned           entry_count = 0;
   logic [LIMIT_W-1:0]    limit_shadow = LIMIT_RESET;

   rsp_word_type          awaited_words [$];
   int unsigned           sender_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           mismatches = 0;
   int unsigned           entries_sent = 0;
   int unsigned           lists_sent = 0;
   int unsigned           words_checked = 0;
   int unsigned           overflow_words = 0;
   int unsigned           over_limit_words = 0;

   first_occurrence_id_assigner_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d words outstanding", awaited_words.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Number one entry the way the block does and advance the shadow state.
   function automatic rsp_word_type number_entry(input logic [REQ_DATA_W-1:0] key,
                                                 input logic last);
      rsp_word_type w;
      bit           hit;
      w   = '0;
      hit = 1'b0;
      if (entry_count >= MAX_KEYS) begin
         w.overflow = 1'b1;
      end else begin
         entry_count++;
         for (int i = 0; i < key_count; i++) begin
            if (!hit && seen_keys[i] == key) begin
               w.assigned_id = ID_OUT_W'(i);
               hit = 1'b1;
            end
         end
         if (!hit && key_count < MAX_KEYS) begin
            w.assigned_id        = ID_OUT_W'(key_count);
            seen_keys[key_count] = key;
            key_count++;
            w.is_new = 1'b1;
         end
      end
      w.distinct_count = CNT_OUT_W'(key_count);
      if (last) begin
         w.over_limit = (key_count > limit_shadow);
         key_count    = 0;
         entry_count  = 0;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on %s: got %0d, expected %0d (word %0d, t=%0t)",
               what, got, want, words_checked, $realtime);
      mismatches++;
   endtask

   // Call right after a rising edge; returns right after the accepting edge.
   task automatic send_entry(input logic [REQ_DATA_W-1:0] key, input logic last,
                             input logic typed, input rsp_word_type typed_word);
      rsp_word_type w;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      w = number_entry(key, last);
      awaited_words.push_back(typed ? typed_word : w);
      entries_sent++;
      if (last)
         lists_sent++;
   endtask

   task automatic send_random_list();
      logic [REQ_DATA_W-1:0] pool [200];
      logic [REQ_DATA_W-1:0] key;
      int unsigned           len;
      int unsigned           pool_size;
      int unsigned           r;
      r = $urandom_range(99);
      if (r < 85)
         len = $urandom_range(1, 24);
      else if (r < 95)
         len = $urandom_range(25, 100);
      else
         len = $urandom_range(120, 140);
      pool_size = (len > 100) ? $urandom_range(60, 200) : $urandom_range(1, len + 1);
      for (int i = 0; i < pool_size; i++) begin
         r = $urandom_range(19);
         pool[i] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : REQ_DATA_W'($urandom);
      end
      for (int k = 0; k < len; k++) begin
         // mostly repeats from the pool, some stray keys
         if ($urandom_range(99) < 90)
            key = pool[$urandom_range(0, pool_size - 1)];
         else
            key = REQ_DATA_W'($urandom);
         send_entry(key, k == len - 1, 1'b0, '0);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      limit_shadow  = value;
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata[RSP_WORD_W-1:0]);
         if (rsp_tdata[RSP_DATA_W-1:RSP_WORD_W] != '0)
            report_mismatch("pad bits", rsp_tdata[RSP_DATA_W-1:RSP_WORD_W], 0);
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected word", got, 0);
         end else begin
            want = awaited_words.pop_front();
            if (got.assigned_id != want.assigned_id)
               report_mismatch("assigned_id", got.assigned_id, want.assigned_id);
            if (got.is_new != want.is_new)
               report_mismatch("is_new", got.is_new, want.is_new);
            if (got.distinct_count != want.distinct_count)
               report_mismatch("distinct_count", got.distinct_count, want.distinct_count);
            if (got.over_limit != want.over_limit)
               report_mismatch("over_limit", got.over_limit, want.over_limit);
            if (got.overflow != want.overflow)
               report_mismatch("overflow", got.overflow, want.overflow);
            overflow_words   += want.overflow;
            over_limit_words += want.over_limit;
         end
         words_checked++;
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limit;
      int unsigned        phase_goal;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset limit, no idling
      foreach (DIR_ROWS[i])
         send_entry(DIR_ROWS[i].key, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].word);

      // fill all cells with distinct keys, then run two entries past capacity
      for (int i = 0; i < MAX_KEYS + 2; i++)
         send_entry(REQ_DATA_W'(i * 517), i == MAX_KEYS + 1, 1'b0, '0);
      drain();

      phase_goal = (ITEM_GOAL - entries_sent) / NUM_PHASES;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: phase_limit = 8'd0;
            1: phase_limit = 8'd128;
            2: phase_limit = 8'd255;
            3: phase_limit = LIMIT_W'($urandom_range(1, 20));
            4: phase_limit = LIMIT_W'($urandom_range(0, 255));
            5: phase_limit = LIMIT_RESET;
            6: phase_limit = LIMIT_W'($urandom_range(1, 10));
            default: phase_limit = LIMIT_W'($urandom_range(100, 255));
         endcase
         write_limit(phase_limit);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin sender_idle_pct = 37; rsp_stall_pct = 37; end
         endcase
         for (int n = entries_sent; entries_sent < n + phase_goal; )
            send_random_list();
         drain();
      end

      rsp_stall_pct = 0;
      repeat (SETTLE_CYC) @(posedge clock);
      $display("%0d entries in %0d lists, %0d words checked under %0d limit settings",
               entries_sent, lists_sent, words_checked, NUM_PHASES + 1);
      $display("%0d dropped-entry words, %0d over-limit words, %0d mismatches",
               overflow_words, over_limit_words, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
hdl/fid_pkg.sv
hdl/fid_cell.sv
hdl/fid_ctrl.sv
hdl/first_occurrence_id_assigner_top.sv
tb/first_occurrence_id_assigner_top_tb.sv
